>>> hw/rtl/gcm_pkg.sv
package gcm_pkg;

    localparam int COIN_BITS      = 16;
    localparam int INDEX_OUT_BITS = 3;
    localparam int CFG_INDEX_BITS = 4;
    localparam int TDATA_BITS     = 40;
    localparam int PAD_BITS       = TDATA_BITS - INDEX_OUT_BITS - 2 * COIN_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } gcm_state_t;

    // Power-on coin set: 1, 2, 5, 10, 20, 50, 100, 200 cents, rest unused.
    function automatic logic [COIN_BITS-1:0] denom_reset(input int idx);
        logic [COIN_BITS-1:0] val;
        case (idx)
            0: val = 16'd1;
            1: val = 16'd2;
            2: val = 16'd5;
            3: val = 16'd10;
            4: val = 16'd20;
            5: val = 16'd50;
            6: val = 16'd100;
            7: val = 16'd200;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/gcm_denom_bank.sv
module gcm_denom_bank
    import gcm_pkg::*;
#(
    parameter int NUM_DENOMS = 8,
    parameter int IDX_BITS   = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COIN_BITS-1:0]      cfg_wdata,
    input  logic [IDX_BITS-1:0]       rd_idx,
    output logic [COIN_BITS-1:0]      rd_data
);

    logic [COIN_BITS-1:0] denom_reg [NUM_DENOMS];

    // indexes at or beyond NUM_DENOMS match no slot and are dropped
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_DENOMS; i++) begin
            if (!aresetn) begin
                denom_reg[i] <= denom_reset(i);
            end else if (cfg_wen && cfg_index == CFG_INDEX_BITS'(i)) begin
                denom_reg[i] <= cfg_wdata;
            end
        end
    end

    assign rd_data = denom_reg[rd_idx];

endmodule

>>> hw/rtl/gcm_serial_div.sv
module gcm_serial_div
    import gcm_pkg::*;
#(
    parameter int AMOUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [AMOUNT_BITS-1:0] dividend,
    input  logic [COIN_BITS-1:0]   divisor,
    output logic                   done,
    output logic [AMOUNT_BITS-1:0] quotient,
    output logic [COIN_BITS-1:0]   remainder
);

    localparam int CNT_BITS = (AMOUNT_BITS > 1) ? $clog2(AMOUNT_BITS) : 1;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [COIN_BITS-1:0]   acc_reg, acc_next;
    logic [AMOUNT_BITS-1:0] q_reg, q_next;
    logic [COIN_BITS-1:0]   dvs_reg, dvs_next;

    logic [COIN_BITS:0]     trial;
    logic [COIN_BITS:0]     diff;
    logic                   fits;

    // restoring division, one quotient bit per cycle, MSB first
    assign trial = {acc_reg, q_reg[AMOUNT_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            acc_next = fits ? diff[COIN_BITS-1:0] : trial[COIN_BITS-1:0];
            q_next   = {q_reg[AMOUNT_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(AMOUNT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = acc_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> divisor != '0)
        else $error("divider started with zero divisor");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> acc_reg < dvs_reg)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished division");

endmodule

>>> hw/rtl/greedy_change_maker_top.sv
// Greedy change maker.
// s_axis carries one request: the amount in cents. m_axis returns one result
// per denomination used, largest first: tdata holds the register index, the
// coin value and the coin count, tlast marks the final result of a request,
// and tuser flags a remainder that no denomination fits (that result then has
// index, value and count of zero). A zero amount gives one empty tlast result.
// cfg_wen/cfg_index/cfg_wdata write the denomination registers; zero disables
// a slot, writes to slots at or above NUM_DENOMS are dropped.
// Flow: each round scans all NUM_DENOMS slots (one per cycle) for the next
// smaller denomination, then a bit-serial divider divides the remainder by
// it; a request needs up to NUM_DENOMS dividing rounds and one last scan. A
// zero amount answers in the cycle after acceptance. One request is in flight
// at a time: s_axis_tready is high only while idle. A stalled receiver simply
// holds the result register and the search waits. Reset restores the 1..200
// cent coin set and drops any request.
module greedy_change_maker_top
    import gcm_pkg::*;
#(
    parameter int NUM_DENOMS  = 8,
    parameter int AMOUNT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [COIN_BITS-1:0]      s_axis_tdata,  // [15:0] amount
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [2:0] denom_index, [18:3] coin_value, [34:19] coin_count, [39:35] zero
    output logic [TDATA_BITS-1:0]     m_axis_tdata,
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser,  // [0] no_solution
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COIN_BITS-1:0]      cfg_wdata
);

    localparam int IDX_BITS = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

    gcm_state_t state_reg, state_next;

    logic [AMOUNT_BITS-1:0]    rem_reg, rem_next;
    logic [COIN_BITS:0]        bound_reg, bound_next;
    logic [COIN_BITS-1:0]      best_reg, best_next;
    logic [IDX_BITS-1:0]       best_idx_reg, best_idx_next;
    logic [IDX_BITS-1:0]       scan_idx_reg, scan_idx_next;

    logic                      m_valid_reg, m_valid_next;
    logic [INDEX_OUT_BITS-1:0] out_idx_reg, out_idx_next;
    logic [COIN_BITS-1:0]      out_value_reg, out_value_next;
    logic [COIN_BITS-1:0]      out_count_reg, out_count_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_nosol_reg, out_nosol_next;

    logic [COIN_BITS-1:0]      cand;
    logic                      take;
    logic [COIN_BITS-1:0]      best_sel;
    logic [IDX_BITS-1:0]       idx_sel;

    logic                      div_start;
    logic                      div_done;
    logic [AMOUNT_BITS-1:0]    div_quot;
    logic [COIN_BITS-1:0]      div_rem;

    logic [31:0]               amount_wide;
    logic [AMOUNT_BITS-1:0]    amount_in;
    logic [31:0]               rem_wide;
    logic [31:0]               quot_wide;
    logic [COIN_BITS-1:0]      count_sat;
    logic [31:0]               idx_wide;

    gcm_denom_bank #(
        .NUM_DENOMS (NUM_DENOMS),
        .IDX_BITS   (IDX_BITS)
    ) u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_idx    (scan_idx_reg),
        .rd_data   (cand)
    );

    gcm_serial_div #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (best_sel),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign amount_wide = 32'(s_axis_tdata);
    assign amount_in   = amount_wide[AMOUNT_BITS-1:0];
    assign rem_wide    = 32'(div_rem);
    assign quot_wide   = 32'(div_quot);
    assign count_sat   = (|quot_wide[31:COIN_BITS]) ? '1 : quot_wide[COIN_BITS-1:0];
    assign idx_wide    = 32'(best_idx_reg);

    // strict compare keeps the lowest slot among equal values
    assign take     = (cand != '0) && ({1'b0, cand} < bound_reg) && (cand > best_reg);
    assign best_sel = take ? cand : best_reg;
    assign idx_sel  = take ? scan_idx_reg : best_idx_reg;

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        bound_next     = bound_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        scan_idx_next  = scan_idx_reg;
        m_valid_next   = m_valid_reg;
        out_idx_next   = out_idx_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_nosol_next = out_nosol_reg;
        div_start      = 1'b0;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    rem_next      = amount_in;
                    bound_next    = {1'b1, {COIN_BITS{1'b0}}};
                    best_next     = '0;
                    best_idx_next = '0;
                    scan_idx_next = '0;
                    if (amount_in == '0) begin
                        m_valid_next   = 1'b1;
                        out_idx_next   = '0;
                        out_value_next = '0;
                        out_count_next = '0;
                        out_last_next  = 1'b1;
                        out_nosol_next = 1'b0;
                        state_next     = ST_EMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                best_next     = best_sel;
                best_idx_next = idx_sel;
                if (scan_idx_reg == IDX_BITS'(NUM_DENOMS - 1)) begin
                    if (best_sel == '0) begin
                        // remainder left and nothing smaller to try
                        m_valid_next   = 1'b1;
                        out_idx_next   = '0;
                        out_value_next = '0;
                        out_count_next = '0;
                        out_last_next  = 1'b1;
                        out_nosol_next = 1'b1;
                        state_next     = ST_EMIT;
                    end else begin
                        div_start  = 1'b1;
                        bound_next = {1'b0, best_sel};
                        state_next = ST_DIV;
                    end
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    rem_next      = rem_wide[AMOUNT_BITS-1:0];
                    best_next     = '0;
                    best_idx_next = '0;
                    scan_idx_next = '0;
                    if (div_quot != '0) begin
                        m_valid_next   = 1'b1;
                        out_idx_next   = idx_wide[INDEX_OUT_BITS-1:0];
                        out_value_next = best_reg;
                        out_count_next = count_sat;
                        out_last_next  = (div_rem == '0);
                        out_nosol_next = 1'b0;
                        state_next     = ST_EMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    m_valid_next = 1'b0;
                    state_next   = out_last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_next_hold: begin
            rem_reg       <= rem_next;
            bound_reg     <= bound_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            scan_idx_reg  <= scan_idx_next;
            out_idx_reg   <= out_idx_next;
            out_value_reg <= out_value_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
            out_nosol_reg <= out_nosol_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, out_count_reg, out_value_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_nosol_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_valid_reg)
        else $error("request taken while a result is pending");

    a_nosol_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_nosol_reg) |-> (out_last_reg && out_count_reg == '0))
        else $error("no-solution result not final or not empty");

    a_mid_result_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_last_reg) |-> out_count_reg != '0)
        else $error("intermediate result with zero coins");

    a_bound_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> ({1'b0, best_reg} == bound_reg && best_reg != '0))
        else $error("division without a selected denomination");

endmodule

>>> tb/greedy_change_maker_top_tb.sv
`timescale 1ns / 1ps

module greedy_change_maker_top_tb;
    import gcm_pkg::*;

    localparam int NUM_COINS    = 8;
    localparam int TAIL_CYCLES  = 250;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int RANDOM_SETS  = 8;
    localparam int SET_REQUESTS = 20;
    localparam int PLAN_ROWS    = 46;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
        logic [15:0] count;
        logic        last;
        logic        no_fit;
    } change_t;

    typedef enum logic {
        ROW_COIN,
        ROW_AMOUNT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [3:0]  slot;
        logic [15:0] data;
        logic        fixed;
        change_t     want;
    } plan_row_t;

    typedef enum int {
        MIX_STOCK,
        MIX_SMALL,
        MIX_WIDE,
        MIX_TWINS,
        MIX_PENNY
    } coin_mix_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [COIN_BITS-1:0]      s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0]     m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      m_axis_tuser;
    logic                      cfg_wen       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [COIN_BITS-1:0]      cfg_wdata     = '0;

    logic [15:0] coin_set [NUM_COINS];
    change_t     expected_change [$];
    plan_row_t   plan [PLAN_ROWS];
    int          errors     = 0;
    int          stall_left = 0;
    bit          calm       = 1'b0;

    greedy_change_maker_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [15:0] stock_coin(input int slot);
        case (slot)
            0: return 16'd1;
            1: return 16'd2;
            2: return 16'd5;
            3: return 16'd10;
            4: return 16'd20;
            5: return 16'd50;
            6: return 16'd100;
            default: return 16'd200;
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Greedy walk over distinct nonzero coins, largest first; ties go to the lowest slot.
    function automatic void predict_change(input logic [15:0] amt);
        logic [31:0] rest;
        logic [31:0] bound;
        logic [31:0] best;
        logic [31:0] cnt;
        logic [2:0]  best_slot;
        change_t     c;
        bit          exhausted;
        rest      = {16'd0, amt};
        bound     = 32'h10000;
        exhausted = 1'b0;
        if (rest == 0) begin
            c = '{3'd0, 16'd0, 16'd0, 1'b1, 1'b0};
            expected_change.push_back(c);
            return;
        end
        for (int round = 0; round < NUM_COINS; round++) begin
            if (rest != 0 && !exhausted) begin
                best      = 0;
                best_slot = 0;
                for (int i = 0; i < NUM_COINS; i++) begin
                    if (coin_set[i] != 0 && coin_set[i] < bound && coin_set[i] > best) begin
                        best      = coin_set[i];
                        best_slot = 3'(i);
                    end
                end
                if (best == 0) begin
                    exhausted = 1'b1;
                end else begin
                    bound = best;
                    cnt   = rest / best;
                    if (cnt != 0) begin
                        rest     = rest - cnt * best;
                        c.index  = best_slot;
                        c.value  = best[15:0];
                        c.count  = (cnt > 32'hFFFF) ? 16'hFFFF : cnt[15:0];
                        c.last   = (rest == 0);
                        c.no_fit = 1'b0;
                        expected_change.push_back(c);
                    end
                end
            end
        end
        if (rest != 0) begin
            c = '{3'd0, 16'd0, 16'd0, 1'b1, 1'b1};
            expected_change.push_back(c);
        end
    endfunction

    function automatic plan_row_t ask(input logic [15:0] amt);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_AMOUNT;
        r.data = amt;
        return r;
    endfunction

    function automatic plan_row_t ask_fixed(input logic [15:0] amt, input logic [2:0] idx,
                                            input logic [15:0] val, input logic [15:0] cnt,
                                            input logic no_fit);
        plan_row_t r;
        r       = ask(amt);
        r.fixed = 1'b1;
        r.want  = '{idx, val, cnt, 1'b1, no_fit};
        return r;
    endfunction

    function automatic plan_row_t set_coin(input logic [3:0] slot, input logic [15:0] val);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_COIN;
        r.slot = slot;
        r.data = val;
        return r;
    endfunction

    function automatic logic [15:0] random_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'd0;
        if (r < 60) return 16'($urandom_range(1, 500));
        if (r < 80) return 16'($urandom_range(1, 5000));
        if (r < 95) return 16'($urandom_range(0, 65535));
        return 16'(coin_set[$urandom_range(0, NUM_COINS - 1)] * $urandom_range(1, 5));
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic write_coin(input logic [3:0] slot, input logic [15:0] val);
        cfg_wen   = 1'b1;
        cfg_index = slot;
        cfg_wdata = val;
        if (slot < NUM_COINS) coin_set[slot[2:0]] = val;
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid = 1'b0;
        while (expected_change.size() != 0) @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
    endtask

    // tvalid stays high on a zero gap so it is never dropped and raised in one step.
    task automatic send_amount(input logic [15:0] amt, input logic fixed, input change_t want);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = amt;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (fixed) expected_change.push_back(want);
        else predict_change(amt);
        @(negedge aclk);
    endtask

    task automatic shuffle_coins();
        coin_mix_t   mix;
        logic [15:0] pool [3];
        logic [15:0] val;
        mix = coin_mix_t'($urandom_range(0, 4));
        for (int k = 0; k < 3; k++) pool[k] = 16'($urandom_range(1, 60));
        for (int i = 0; i < NUM_COINS; i++) begin
            case (mix)
                MIX_STOCK: val = stock_coin(i);
                MIX_SMALL: val = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
                MIX_WIDE:  val = ($urandom_range(0, 4) == 0) ? 16'd0
                                                             : 16'($urandom_range(0, 65535));
                MIX_TWINS: val = pool[$urandom_range(0, 2)];
                default:   val = (i == 0) ? 16'd1 : 16'($urandom_range(0, 500));
            endcase
            if (mix == MIX_STOCK || $urandom_range(0, 4) != 0) write_coin(4'(i), val);
        end
        // slots past the last coin must not take the write
        if ($urandom_range(0, 2) == 0)
            write_coin(4'($urandom_range(NUM_COINS, 15)), 16'($urandom_range(0, 65535)));
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = idle_len();
        end
    end

    always @(posedge aclk) begin
        change_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_change.size() == 0) begin
                $error("result with no request waiting: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_change.pop_front();
                check_field("denom_index", 16'(want.index), 16'(m_axis_tdata[2:0]));
                check_field("coin_value", want.value, m_axis_tdata[18:3]);
                check_field("coin_count", want.count, m_axis_tdata[34:19]);
                check_field("pad", 16'd0, 16'(m_axis_tdata[39:35]));
                check_field("last", 16'(want.last), 16'(m_axis_tlast));
                check_field("no_solution", 16'(want.no_fit), 16'(m_axis_tuser));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("greedy_change_maker_top test failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_COINS; i++) coin_set[i] = stock_coin(i);
        plan = '{
            ask_fixed(16'd0, 3'd0, 16'd0, 16'd0, 1'b0),
            ask_fixed(16'd1, 3'd0, 16'd1, 16'd1, 1'b0),
            ask_fixed(16'd200, 3'd7, 16'd200, 16'd1, 1'b0),
            ask(16'd65535),
            ask(16'd388),               // every stock coin once
            ask(16'd3),
            set_coin(4'd8, 16'd1234),   // out of range, dropped
            set_coin(4'd15, 16'hFFFF),
            ask(16'd7),
            set_coin(4'd0, 16'hFFFF),
            set_coin(4'd1, 16'd0),
            set_coin(4'd2, 16'd0),
            set_coin(4'd3, 16'd0),
            set_coin(4'd4, 16'd0),
            set_coin(4'd5, 16'd0),
            set_coin(4'd6, 16'd0),
            set_coin(4'd7, 16'd0),
            ask_fixed(16'd65535, 3'd0, 16'hFFFF, 16'd1, 1'b0),
            ask_fixed(16'd65534, 3'd0, 16'd0, 16'd0, 1'b1),
            ask_fixed(16'd0, 3'd0, 16'd0, 16'd0, 1'b0),
            set_coin(4'd0, 16'd3),
            set_coin(4'd3, 16'd7),      // same value twice: slot 3 reports
            set_coin(4'd7, 16'd7),
            ask_fixed(16'd14, 3'd3, 16'd7, 16'd2, 1'b0),
            ask(16'd17),
            ask_fixed(16'd1, 3'd0, 16'd0, 16'd0, 1'b1),
            ask(16'd18),                // partial change, then no fit
            ask(16'd65535),
            set_coin(4'd0, 16'd0),
            set_coin(4'd3, 16'd0),
            set_coin(4'd7, 16'd0),
            ask_fixed(16'd5, 3'd0, 16'd0, 16'd0, 1'b1),
            ask_fixed(16'd0, 3'd0, 16'd0, 16'd0, 1'b0),
            set_coin(4'd0, 16'd1),
            ask_fixed(16'd65535, 3'd0, 16'd1, 16'hFFFF, 1'b0),
            set_coin(4'd1, 16'h8000),
            set_coin(4'd2, 16'h5555),
            set_coin(4'd4, 16'hAAAA),
            set_coin(4'd5, 16'd255),
            set_coin(4'd6, 16'h0F0F),
            set_coin(4'd7, 16'hFFFF),
            ask(16'd65535),
            ask(16'hAAAA),
            ask(16'h5555),
            ask(16'h7FFF),
            ask(16'd1)
        };

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_COIN) begin
                wait_all_results();
                write_coin(plan[r].slot, plan[r].data);
            end else begin
                send_amount(plan[r].data, plan[r].fixed, plan[r].want);
            end
        end

        for (int set = 0; set < RANDOM_SETS; set++) begin
            wait_all_results();
            calm = (set % 3 == 2);
            shuffle_coins();
            for (int n = 0; n < SET_REQUESTS; n++) begin
                // occasionally hold the next request until the block has drained
                if ($urandom_range(0, 24) == 0) wait_all_results();
                send_amount(random_amount(), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0 && expected_change.size() == 0) begin
            $display("greedy_change_maker_top test passed");
        end else begin
            $display("greedy_change_maker_top test failed");
        end
        $finish;
    end

endmodule
